[rtl/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Action codes, command and result words, and the back-end state encoding.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Action codes as they arrive on the input port.
  localparam logic [1:0] ACT_PUT  = 2'd0;
  localparam logic [1:0] ACT_READ = 2'd1;
  localparam logic [1:0] ACT_SET  = 2'd2;

  localparam logic [7:0] NEWLINE_CODE = 8'h0a;
  localparam logic [7:0] ATTR_RESET   = 8'h0f;

  // Classified operation handed from the front end to the back end.
  typedef enum logic [2:0] {
    OP_PUT,
    OP_NEWLINE,
    OP_READ,
    OP_SET,
    OP_NOP
  } tcw_op_t;

  // The cell index is already clamped to the cell count, and in_range tells
  // whether it addresses a real cell.
  typedef struct packed {
    tcw_op_t     op;
    logic [7:0]  char_code;
    logic [10:0] cell_index;
    logic        in_range;
  } tcw_cmd_t;

  typedef struct packed {
    logic [10:0] cursor_pos;
    logic [7:0]  read_char;
    logic [7:0]  read_attr;
    logic        scrolled;
  } tcw_result_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_TAIL,
    ST_WRITE,
    ST_READ,
    ST_MOD,
    ST_DONE
  } tcw_state_t;

endpackage

[rtl/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram: generic single-write, single-read memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/tcw_fifo.sv]
// ----------------------------------------------------------------------------
// tcw_fifo: small first-in first-out queue of words
// Used for the command queue and for the result queue.
// ----------------------------------------------------------------------------
module tcw_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

  logic [WIDTH-1:0] slot_r [DEPTH];
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [PW-1:0]    rptr_r, rptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_FULL);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = slot_r[rptr_r];

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (do_push) begin
      slot_r[wptr_r] <= din;
    end
  end

endmodule

[rtl/tcw_front.sv]
// ----------------------------------------------------------------------------
// tcw_front: input classification and command queue
// Decodes each accepted item into an operation, clamps the cell index and
// queues the command for the back end.
// ----------------------------------------------------------------------------
module tcw_front #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  logic [1:0]        in_action,
  input  logic [7:0]        in_char_code,
  input  logic [10:0]       in_cell_index,
  output logic              in_full,
  input  logic              cmd_pop,
  output tcw_pkg::tcw_cmd_t cmd,
  output logic              cmd_empty
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int CW = $clog2(CELL_COUNT + 1);
  localparam int XW = (CW > 11) ? CW : 11;
  localparam logic [XW-1:0] CELL_X = XW'(CELL_COUNT);

  tcw_pkg::tcw_cmd_t cmd_in;
  logic [XW-1:0]     idx_x;
  logic [$bits(tcw_pkg::tcw_cmd_t)-1:0] cmd_word;

  assign idx_x = XW'(in_cell_index);

  always_comb begin
    cmd_in.char_code = in_char_code;
    cmd_in.in_range  = (idx_x < CELL_X);
    // Past the end the index is clamped, which only happens when the cell
    // count itself fits the 11-bit field.
    cmd_in.cell_index = (idx_x > CELL_X) ? 11'(CELL_X) : in_cell_index;
    unique case (in_action)
      tcw_pkg::ACT_PUT: begin
        cmd_in.op = (in_char_code == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                            : tcw_pkg::OP_PUT;
      end
      tcw_pkg::ACT_READ: cmd_in.op = tcw_pkg::OP_READ;
      tcw_pkg::ACT_SET:  cmd_in.op = tcw_pkg::OP_SET;
      default:           cmd_in.op = tcw_pkg::OP_NOP;
    endcase
  end

  tcw_fifo #(
    .WIDTH($bits(tcw_pkg::tcw_cmd_t)),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (cmd_in),
    .full  (in_full),
    .pop   (cmd_pop),
    .dout  (cmd_word),
    .empty (cmd_empty)
  );

  assign cmd = tcw_pkg::tcw_cmd_t'(cmd_word);

endmodule

[rtl/tcw_back.sv]
// ----------------------------------------------------------------------------
// tcw_back: screen store sequencer
// Owns the screen memory, the cursor and the attribute register, and carries
// out one command at a time: clear after reset, put, newline, scroll, read
// and set cursor.
// ----------------------------------------------------------------------------
module tcw_back #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_text_attribute,
  input  tcw_pkg::tcw_cmd_t    cmd,
  input  logic                 cmd_empty,
  output logic                 cmd_pop,
  input  logic                 res_full,
  output logic                 res_push,
  output tcw_pkg::tcw_result_t res,
  output logic                 clearing
);

  localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int LAST_ROW   = CELL_COUNT - SCREEN_COLUMNS;
  localparam int CW   = $clog2(CELL_COUNT + 1);
  localparam int AW   = $clog2(CELL_COUNT);
  localparam int COLW = $clog2(SCREEN_COLUMNS);

  localparam logic [CW-1:0]   CUR_END  = CW'(CELL_COUNT);
  localparam logic [CW-1:0]   CUR_LAST = CW'(LAST_ROW);
  localparam logic [CW-1:0]   CUR_COLS = CW'(SCREEN_COLUMNS);
  localparam logic [AW-1:0]   ADDR_END = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0]   ADDR_LAST_ROW = AW'(LAST_ROW);
  localparam logic [AW-1:0]   ADDR_COLS = AW'(SCREEN_COLUMNS);
  localparam logic [COLW-1:0] COL_END  = COLW'(SCREEN_COLUMNS - 1);

  tcw_pkg::tcw_state_t state_r, state_nxt;

  logic [CW-1:0]   cursor_r, cursor_nxt;
  logic [COLW-1:0] col_r, col_nxt;
  logic [CW-1:0]   rem_r, rem_nxt;
  logic [AW-1:0]   scan_r, scan_nxt;
  logic            pend_r, pend_nxt;
  logic [AW-1:0]   pend_addr_r, pend_addr_nxt;
  logic            pend_clr_r, pend_clr_nxt;
  logic            put_after_r, put_after_nxt;
  logic [7:0]      attr_r;
  logic [7:0]      ch_r, ch_nxt;
  logic [7:0]      rchar_r, rchar_nxt;
  logic [7:0]      rattr_r, rattr_nxt;
  logic            scrolled_r, scrolled_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [15:0]     ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [15:0]     ram_rdata;

  logic            scan_last;
  logic            have_cmd;

  assign scan_last = (scan_r == ADDR_END);
  assign have_cmd  = !cmd_empty;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        if (scan_last) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      tcw_pkg::ST_IDLE: begin
        if (have_cmd) begin
          unique case (cmd.op)
            tcw_pkg::OP_PUT: begin
              state_nxt = (cursor_r == CUR_END) ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_WRITE;
            end
            tcw_pkg::OP_NEWLINE: begin
              state_nxt = (cursor_r >= CUR_LAST) ? tcw_pkg::ST_SCROLL : tcw_pkg::ST_DONE;
            end
            tcw_pkg::OP_READ: begin
              state_nxt = cmd.in_range ? tcw_pkg::ST_READ : tcw_pkg::ST_DONE;
            end
            tcw_pkg::OP_SET: state_nxt = tcw_pkg::ST_MOD;
            default:         state_nxt = tcw_pkg::ST_DONE;
          endcase
        end
      end
      tcw_pkg::ST_SCROLL: begin
        if (scan_last) begin
          state_nxt = tcw_pkg::ST_TAIL;
        end
      end
      tcw_pkg::ST_TAIL: begin
        state_nxt = put_after_r ? tcw_pkg::ST_WRITE : tcw_pkg::ST_DONE;
      end
      tcw_pkg::ST_WRITE: state_nxt = tcw_pkg::ST_DONE;
      tcw_pkg::ST_READ:  state_nxt = tcw_pkg::ST_DONE;
      tcw_pkg::ST_MOD: begin
        if (rem_r < CUR_COLS) begin
          state_nxt = tcw_pkg::ST_DONE;
        end
      end
      tcw_pkg::ST_DONE: begin
        if (!res_full) begin
          state_nxt = tcw_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcw_pkg::ST_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cursor_nxt    = cursor_r;
    col_nxt       = col_r;
    rem_nxt       = rem_r;
    scan_nxt      = scan_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = scan_r;
    pend_clr_nxt  = 1'b0;
    put_after_nxt = put_after_r;
    ch_nxt        = ch_r;
    rchar_nxt     = rchar_r;
    rattr_nxt     = rattr_r;
    scrolled_nxt  = scrolled_r;
    ram_we        = 1'b0;
    ram_waddr     = scan_r;
    ram_wdata     = '0;
    ram_raddr     = AW'(cmd.cell_index);
    cmd_pop       = 1'b0;
    res_push      = 1'b0;

    unique case (state_r)
      tcw_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_r;
        scan_nxt  = scan_r + 1'b1;
      end
      tcw_pkg::ST_IDLE: begin
        if (have_cmd) begin
          cmd_pop       = 1'b1;
          ch_nxt        = cmd.char_code;
          rchar_nxt     = '0;
          rattr_nxt     = '0;
          scrolled_nxt  = 1'b0;
          put_after_nxt = 1'b0;
          scan_nxt      = '0;
          unique case (cmd.op)
            tcw_pkg::OP_PUT: begin
              // At the end position the screen scrolls first and the
              // character lands at the start of the last row.
              if (cursor_r == CUR_END) begin
                cursor_nxt    = CUR_LAST;
                col_nxt       = '0;
                put_after_nxt = 1'b1;
                scrolled_nxt  = 1'b1;
              end
            end
            tcw_pkg::OP_NEWLINE: begin
              col_nxt = '0;
              if (cursor_r >= CUR_LAST) begin
                cursor_nxt   = cursor_r - CW'(col_r);
                scrolled_nxt = 1'b1;
              end else begin
                cursor_nxt = cursor_r - CW'(col_r) + CUR_COLS;
              end
            end
            tcw_pkg::OP_SET: begin
              cursor_nxt = CW'(cmd.cell_index);
              rem_nxt    = CW'(cmd.cell_index);
            end
            default: begin
            end
          endcase
        end
      end
      tcw_pkg::ST_SCROLL: begin
        // Rows move up one; the last row is read back in place so that its
        // attribute bytes survive while its character bytes are cleared.
        if (scan_r < ADDR_LAST_ROW) begin
          ram_raddr    = scan_r + ADDR_COLS;
          pend_clr_nxt = 1'b0;
        end else begin
          ram_raddr    = scan_r;
          pend_clr_nxt = 1'b1;
        end
        pend_nxt      = 1'b1;
        pend_addr_nxt = scan_r;
        scan_nxt      = scan_r + 1'b1;
      end
      tcw_pkg::ST_TAIL: begin
      end
      tcw_pkg::ST_WRITE: begin
        ram_we     = 1'b1;
        ram_waddr  = AW'(cursor_r);
        ram_wdata  = {attr_r, ch_r};
        cursor_nxt = cursor_r + 1'b1;
        col_nxt    = (col_r == COL_END) ? '0 : col_r + 1'b1;
      end
      tcw_pkg::ST_READ: begin
        rchar_nxt = ram_rdata[7:0];
        rattr_nxt = ram_rdata[15:8];
      end
      tcw_pkg::ST_MOD: begin
        if (rem_r >= CUR_COLS) begin
          rem_nxt = rem_r - CUR_COLS;
        end else begin
          col_nxt = COLW'(rem_r);
        end
      end
      tcw_pkg::ST_DONE: begin
        res_push = !res_full;
      end
      default: begin
      end
    endcase

    // Second half of the scroll copy: write the registered read data back to the saved address.
    if (pend_r) begin
      ram_we    = 1'b1;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_clr_r ? {ram_rdata[15:8], 8'h00} : ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcw_pkg::ST_CLEAR;
      cursor_r    <= '0;
      col_r       <= '0;
      scan_r      <= '0;
      pend_r      <= 1'b0;
      put_after_r <= 1'b0;
      attr_r      <= tcw_pkg::ATTR_RESET;
    end else begin
      state_r     <= state_nxt;
      cursor_r    <= cursor_nxt;
      col_r       <= col_nxt;
      scan_r      <= scan_nxt;
      pend_r      <= pend_nxt;
      put_after_r <= put_after_nxt;
      if (cfg_we) begin
        attr_r <= cfg_text_attribute;
      end
    end
    rem_r       <= rem_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_clr_r  <= pend_clr_nxt;
    ch_r        <= ch_nxt;
    rchar_r     <= rchar_nxt;
    rattr_r     <= rattr_nxt;
    scrolled_r  <= scrolled_nxt;
  end

  tcw_ram #(
    .WIDTH(16),
    .DEPTH(CELL_COUNT)
  ) u_screen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    res.cursor_pos = 11'(cursor_r);
    res.read_char  = rchar_r;
    res.read_attr  = rattr_r;
    res.scrolled   = scrolled_r;
  end

  assign clearing = (state_r == tcw_pkg::ST_CLEAR);

endmodule

[rtl/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_writer_top: text screen store with a cursor
// Queue-style input of put, read and set-cursor actions, one result word per
// action, and a write-only attribute register.
// ----------------------------------------------------------------------------
// The block keeps a SCREEN_COLUMNS x SCREEN_ROWS screen of 16-bit cells
// (character in the low byte, attribute in the high byte) and a cursor.
// Every accepted input word produces exactly one result word, in order.
// After reset the screen memory is cleared one cell per cycle; in_full stays
// high until the clear is done, while attribute writes are taken as usual.
// Work per word is set by the back-end sequencer and its screen memory, which
// has one write and one read port: a put passes through a write state, a read
// through a read state, a newline without scroll only moves the cursor, a set
// cursor finds the column by repeated subtraction of the row length, and any
// action that scrolls copies the screen at one cell per cycle through the
// memory's read and write ports. A two-word command queue in front and a
// two-word result queue behind let the input side and the result side stall
// on their own. The attribute register should only be written while the block
// is idle; it is applied to every character written after the write.
module text_console_writer_top #(
  parameter int SCREEN_COLUMNS = 80,
  parameter int SCREEN_ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input channel.
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_char_code,
  input  logic [10:0] in_cell_index,
  // Result channel.
  output logic        out_empty,
  input  logic        out_pop,
  output logic [10:0] out_cursor_pos,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr,
  output logic        out_scrolled,
  // Attribute register.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_text_attribute
);

  tcw_pkg::tcw_cmd_t    cmd;
  tcw_pkg::tcw_result_t res;
  tcw_pkg::tcw_result_t out_word;
  logic [$bits(tcw_pkg::tcw_result_t)-1:0] out_bits;

  logic cmd_empty;
  logic cmd_pop;
  logic front_full;
  logic clearing;
  logic res_full;
  logic res_push;

  // No word is taken while the screen is being cleared after reset.
  assign in_full = front_full || clearing;

  tcw_front #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push && !clearing),
    .in_action     (in_action),
    .in_char_code  (in_char_code),
    .in_cell_index (in_cell_index),
    .in_full       (front_full),
    .cmd_pop       (cmd_pop),
    .cmd           (cmd),
    .cmd_empty     (cmd_empty)
  );

  tcw_back #(
    .SCREEN_COLUMNS(SCREEN_COLUMNS),
    .SCREEN_ROWS   (SCREEN_ROWS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_text_attribute (cfg_text_attribute),
    .cmd                (cmd),
    .cmd_empty          (cmd_empty),
    .cmd_pop            (cmd_pop),
    .res_full           (res_full),
    .res_push           (res_push),
    .res                (res),
    .clearing           (clearing)
  );

  // Result queue: finished results wait here while the next word is worked.
  tcw_fifo #(
    .WIDTH($bits(tcw_pkg::tcw_result_t)),
    .DEPTH(2)
  ) u_res_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .full  (res_full),
    .pop   (out_pop),
    .dout  (out_bits),
    .empty (out_empty)
  );

  assign out_word       = tcw_pkg::tcw_result_t'(out_bits);
  assign out_cursor_pos = out_word.cursor_pos;
  assign out_read_char  = out_word.read_char;
  assign out_read_attr  = out_word.read_attr;
  assign out_scrolled   = out_word.scrolled;

endmodule
